// File: sv/gdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdd_pkg: shared types and constants for the date difference block
// Field widths, order codes, calendar tables and the control structs that
// pass between the sequencer and its shared units.
// ----------------------------------------------------------------------------
package gdd_pkg;

   localparam int MONTH_W      = 4;
   localparam int DAY_W        = 5;
   localparam int YEAR_W       = 14;
   localparam int DIFF_W       = 23;
   localparam int ACC_W        = 24;   // holds the unsaturated day count
   localparam int OPND_W       = 10;   // widest addend: a day-of-year or 366
   localparam int CUM_W        = 9;
   localparam int CENT_W       = 7;    // year modulo 100
   localparam int DEF_MAX_YEAR = 9999;
   localparam int DIFF_LIMIT   = 4194303;
   localparam int MONTHS       = 12;

   localparam logic [1:0] ORD_EQUAL  = 2'd0;
   localparam logic [1:0] ORD_BEFORE = 2'd1;
   localparam logic [1:0] ORD_AFTER  = 2'd2;

   typedef struct packed {
      logic start;   // load year 1
      logic step;    // advance one year
   } cal_ctrl_type;

   typedef struct packed {
      logic              clear;
      logic              en;
      logic              sub;
      logic [OPND_W-1:0] operand;
   } alu_op_type;

   // days in the months before month m
   function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
      logic [CUM_W-1:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] r;
      case (m)
         4'd2:                         r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:      r = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
         4'd10, 4'd12:                 r = 5'd31;
         default:                      r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// File: sv/gdd_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdd_calendar: year walker
// Counts years upward from year 1 and tracks the year modulo 100 and the
// century modulo 4, so the leap flag needs no division.
// ----------------------------------------------------------------------------
module gdd_calendar
   import gdd_pkg::*;
(
   input  logic              clock,
   input  cal_ctrl_type      ctrl,
   output logic [YEAR_W-1:0] year,
   output logic              leap
);

   logic [YEAR_W-1:0] year_ff, year_in;
   logic [CENT_W-1:0] cent_ff, cent_in;   // year mod 100
   logic [1:0]        quad_ff, quad_in;   // centuries mod 4
   logic              wrap;

   assign wrap = (cent_ff == CENT_W'(99));

   always_comb begin
      year_in = year_ff;
      cent_in = cent_ff;
      quad_in = quad_ff;
      if (ctrl.start) begin
         year_in = YEAR_W'(1);
         cent_in = CENT_W'(1);
         quad_in = 2'd0;
      end else if (ctrl.step) begin
         year_in = year_ff + YEAR_W'(1);
         cent_in = wrap ? '0 : cent_ff + CENT_W'(1);
         quad_in = quad_ff + 2'(wrap);
      end
   end

   always_ff @(posedge clock) begin
      year_ff <= year_in;
      cent_ff <= cent_in;
      quad_ff <= quad_in;
   end

   assign year = year_ff;
   // divisible by 4, and not a century unless the century count is a multiple of 4
   assign leap = (year_ff[1:0] == 2'd0) && ((cent_ff != '0) || (quad_ff == 2'd0));

endmodule

// File: sv/gdd_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdd_alu: shared accumulator
// One add/subtract unit with its accumulator; every day count in the block
// goes through here, one operand per cycle.
// ----------------------------------------------------------------------------
module gdd_alu
   import gdd_pkg::*;
(
   input  logic                    clock,
   input  alu_op_type              op,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] opnd;

   assign opnd = signed'(ACC_W'(op.operand));

   always_comb begin
      acc_in = acc_ff;
      if (op.clear) begin
         acc_in = '0;
      end else if (op.en) begin
         acc_in = op.sub ? acc_ff - opnd : acc_ff + opnd;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: sv/gregorian_date_difference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_difference: signed day count between two calendar dates
// Checks dates A and B and returns their order and A minus B in days.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one item: both dates packed in req_tdata. rsp_* returns one
//   item per request: order and day difference in rsp_tdata, the two
//   validity flags in rsp_tuser.
//   The sequencer walks years from 1 up to the larger valid year, one year a
//   cycle through a single shared adder, then adds A's day-of-year offset and
//   subtracts B's. rsp_tvalid rises, and req_tready with it, once the walk
//   and both offsets are done; when both years are out of range there is no
//   walk. The larger valid year, up to MAX_YEAR, sets how long the walk runs.
//   req_tready is low while an item is in work, one item at a time.
//   The finished result sits in an output register; a new request is taken
//   while it waits. If the receiver stalls, the next item finishes its walk
//   and then holds until the register frees.
//   Reset empties the output register and returns the sequencer to idle;
//   there is no other state and no clearing pass.
// ----------------------------------------------------------------------------
module gregorian_date_difference
   import gdd_pkg::*;
#(
   parameter int MAX_YEAR = DEF_MAX_YEAR
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // month_a[3:0], day_a[8:4], year_a[22:9], month_b[26:23], day_b[31:27],
   // year_b[45:32], zero pad [47:46]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // order[1:0], day_difference[24:2], zero pad [31:25]
   output logic [31:0] rsp_tdata,
   // valid_a[0], valid_b[1]
   output logic [1:0]  rsp_tuser
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SWEEP = 5'b00010,
      ST_DOY_A = 5'b00100,
      ST_DOY_B = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(MAX_YEAR);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(DIFF_LIMIT);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;

   state_type state_ff, state_in;

   logic [MONTH_W-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [DAY_W-1:0]   da_ff, da_in, db_ff, db_in;
   logic [YEAR_W-1:0]  ya_ff, ya_in, yb_ff, yb_in;
   logic [YEAR_W-1:0]  end_ff, end_in;
   logic               leap_a_ff, leap_a_in, leap_b_ff, leap_b_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;
   logic [1:0]         ord_ff, ord_in;
   logic [DIFF_W-1:0]  diff_ff, diff_in;

   logic [MONTH_W-1:0] req_ma, req_mb;
   logic [DAY_W-1:0]   req_da, req_db;
   logic [YEAR_W-1:0]  req_ya, req_yb, ya_lim, yb_lim;

   cal_ctrl_type            cal_ctrl;
   alu_op_type              alu_op;
   logic [YEAR_W-1:0]       cal_year;
   logic                    cal_leap;
   logic signed [ACC_W-1:0] acc;

   logic               accept, out_free;
   logic               below_a, below_b;
   logic [OPND_W-1:0]  doy_a, doy_b;
   logic               ok_a, ok_b;

   assign req_ma = req_tdata[3:0];
   assign req_da = req_tdata[8:4];
   assign req_ya = req_tdata[22:9];
   assign req_mb = req_tdata[26:23];
   assign req_db = req_tdata[31:27];
   assign req_yb = req_tdata[45:32];

   // out-of-range years take no part in the walk
   assign ya_lim = (req_ya > YEAR_MAX) ? '0 : req_ya;
   assign yb_lim = (req_yb > YEAR_MAX) ? '0 : req_yb;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign below_a = (cal_year < ya_ff);
   assign below_b = (cal_year < yb_ff);

   assign doy_a = OPND_W'(cum_days(ma_ff)) + OPND_W'(da_ff)
                  + OPND_W'(leap_a_ff && (ma_ff > MONTH_W'(2)));
   assign doy_b = OPND_W'(cum_days(mb_ff)) + OPND_W'(db_ff)
                  + OPND_W'(leap_b_ff && (mb_ff > MONTH_W'(2)));

   assign ok_a = (ya_ff != '0) && (ya_ff <= YEAR_MAX)
                 && (ma_ff inside {[1:MONTHS]})
                 && (da_ff != '0) && (da_ff <= month_len(ma_ff, leap_a_ff));
   assign ok_b = (yb_ff != '0) && (yb_ff <= YEAR_MAX)
                 && (mb_ff inside {[1:MONTHS]})
                 && (db_ff != '0) && (db_ff <= month_len(mb_ff, leap_b_ff));

   always_comb begin
      state_in     = state_ff;
      ma_in        = ma_ff;
      da_in        = da_ff;
      ya_in        = ya_ff;
      mb_in        = mb_ff;
      db_in        = db_ff;
      yb_in        = yb_ff;
      end_in       = end_ff;
      leap_a_in    = leap_a_ff;
      leap_b_in    = leap_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      ord_in       = ord_ff;
      diff_in      = diff_ff;
      cal_ctrl     = '0;
      alu_op       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ma_in          = req_ma;
               da_in          = req_da;
               ya_in          = req_ya;
               mb_in          = req_mb;
               db_in          = req_db;
               yb_in          = req_yb;
               end_in         = (ya_lim > yb_lim) ? ya_lim : yb_lim;
               leap_a_in      = 1'b0;
               leap_b_in      = 1'b0;
               cal_ctrl.start = 1'b1;
               alu_op.clear   = 1'b1;
               state_in       = (ya_lim == '0 && yb_lim == '0) ? ST_DOY_A : ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // years before A count up, years before B count down
            alu_op.en      = below_a ^ below_b;
            alu_op.sub     = below_b;
            alu_op.operand = cal_leap ? OPND_W'(366) : OPND_W'(365);
            if (cal_year == ya_ff) begin
               leap_a_in = cal_leap;
            end
            if (cal_year == yb_ff) begin
               leap_b_in = cal_leap;
            end
            if (cal_year == end_ff) begin
               state_in = ST_DOY_A;
            end else begin
               cal_ctrl.step = 1'b1;
            end
         end
         ST_DOY_A: begin
            alu_op.en      = 1'b1;
            alu_op.operand = doy_a;
            state_in       = ST_DOY_B;
         end
         ST_DOY_B: begin
            alu_op.en      = 1'b1;
            alu_op.sub     = 1'b1;
            alu_op.operand = doy_b;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = {ok_b, ok_a};
               ord_in       = ORD_EQUAL;
               diff_in      = '0;
               if (ok_a && ok_b) begin
                  if (acc < 0) begin
                     ord_in = ORD_BEFORE;
                  end else if (acc > 0) begin
                     ord_in = ORD_AFTER;
                  end
                  if (acc > SAT_HI) begin
                     diff_in = SAT_HI[DIFF_W-1:0];
                  end else if (acc < SAT_LO) begin
                     diff_in = SAT_LO[DIFF_W-1:0];
                  end else begin
                     diff_in = acc[DIFF_W-1:0];
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff       <= ma_in;
      da_ff       <= da_in;
      ya_ff       <= ya_in;
      mb_ff       <= mb_in;
      db_ff       <= db_in;
      yb_ff       <= yb_in;
      end_ff      <= end_in;
      leap_a_ff   <= leap_a_in;
      leap_b_ff   <= leap_b_in;
      rsp_user_ff <= rsp_user_in;
      ord_ff      <= ord_in;
      diff_ff     <= diff_in;
   end

   gdd_calendar u_calendar (
      .clock (clock),
      .ctrl  (cal_ctrl),
      .year  (cal_year),
      .leap  (cal_leap)
   );

   gdd_alu u_alu (
      .clock (clock),
      .op    (alu_op),
      .acc   (acc)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, diff_ff, ord_ff};
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // the year walk never passes its end year
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (cal_year <= end_ff))
      else $error("year walk overran its end year");

   // an order is only reported for two valid dates
   a_order_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != ORD_EQUAL) |-> (rsp_tuser == 2'b11))
      else $error("order reported for an invalid date");

   // equal order goes with a zero difference
   a_equal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == ORD_EQUAL) |-> (rsp_tdata[24:2] == '0))
      else $error("nonzero difference with equal order");

   // an accepted item keeps the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while an item is in work");
`endif

endmodule

// File: tb/sv/gregorian_date_difference_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_difference_tb: self-checking bench for the date difference
// Drives date pairs into the request stream and predicts validity, order and
// signed day count for each one. Every response is checked against the
// oldest prediction. A directed set covering calendar edges comes first.
// A burst of short queries is then sent against a long receiver hold. The
// rest is random, mostly valid dates with small years.
// ----------------------------------------------------------------------------
module gregorian_date_difference_tb;
   import gdd_pkg::*;

   localparam int LAST_YEAR   = DEF_MAX_YEAR;
   localparam int RANDOM_ITEMS = 67;
   localparam int BURST_ITEMS = 10;
   localparam int TAIL_ITEMS  = 20;
   localparam int LONG_HOLD   = 400;
   localparam int QUIET_LIMIT = 60000;   // several times the longest year walk

   typedef struct {
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [YEAR_W-1:0]  year;
   } cal_date_type;

   typedef struct {
      cal_date_type a;
      cal_date_type b;
      bit           drain_first;   // hold back until every response is in
   } date_pair_type;

   typedef struct packed {
      logic                     valid_a;
      logic                     valid_b;
      logic [1:0]               order;
      logic signed [DIFF_W-1:0] diff;
   } day_count_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   date_pair_type date_pairs_q[$];
   day_count_type awaited_counts[$];
   date_pair_type offered_pair;
   int          sent_count = 0;
   int          rsp_count = 0;
   int          directed_count = 0;
   int          err_count = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          tail_phase = 1'b0;
   int unsigned quiet_cycles = 0;

   gregorian_date_difference #(.MAX_YEAR(LAST_YEAR)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------ calendar
   function automatic int days_in_month(input int m, input int y);
      bit leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
         2:                      return leap ? 29 : 28;
         4, 6, 9, 11:            return 30;
         1, 3, 5, 7, 8, 10, 12:  return 31;
         default:                return 0;
      endcase
   endfunction

   function automatic bit date_is_valid(input cal_date_type d);
      if (d.year < 1 || d.year > LAST_YEAR) return 1'b0;
      if (d.month < 1 || d.month > MONTHS) return 1'b0;
      return d.day >= 1 && d.day <= days_in_month(int'(d.month), int'(d.year));
   endfunction

   // day 1 is 1 January of year 1
   function automatic longint day_number(input cal_date_type d);
      longint prior;
      longint n;
      prior = longint'(d.year) - 1;
      n = prior * 365 + prior / 4 - prior / 100 + prior / 400;
      for (int i = 1; i < d.month; i++) n += days_in_month(i, int'(d.year));
      return n + d.day;
   endfunction

   function automatic day_count_type predict_difference(input date_pair_type p);
      day_count_type r;
      longint        span;
      r.valid_a = date_is_valid(p.a);
      r.valid_b = date_is_valid(p.b);
      r.order   = ORD_EQUAL;
      r.diff    = '0;
      if (r.valid_a && r.valid_b) begin
         span = day_number(p.a) - day_number(p.b);
         if (span < 0) r.order = ORD_BEFORE;
         else if (span > 0) r.order = ORD_AFTER;
         if (span > DIFF_LIMIT) span = DIFF_LIMIT;
         if (span < -DIFF_LIMIT) span = -DIFF_LIMIT;
         r.diff = span[DIFF_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [47:0] pack_pair(input date_pair_type p);
      return {2'b00, p.b.year, p.b.day, p.b.month, p.a.year, p.a.day, p.a.month};
   endfunction

   // ------------------------------------------------------------ stimulus
   // mostly small years, as the walk grows longer with each year
   function automatic logic [YEAR_W-1:0] random_year();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return YEAR_W'($urandom_range(1, 400));
      else if (r < 80) return YEAR_W'($urandom_range(1, 2100));
      else if (r < 84) return YEAR_W'($urandom_range(1, LAST_YEAR));
      else if (r < 89) return YEAR_W'(100 * $urandom_range(1, 24));   // century years
      else if (r < 94) return '0;
      else return YEAR_W'($urandom_range(LAST_YEAR + 1, (1 << YEAR_W) - 1));
   endfunction

   function automatic logic [MONTH_W-1:0] random_month();
      int v;
      if ($urandom_range(0, 99) < 92) return MONTH_W'($urandom_range(1, MONTHS));
      v = $urandom_range(0, 3);
      return (v == 0) ? '0 : MONTH_W'(MONTHS + v);
   endfunction

   function automatic logic [DAY_W-1:0] random_day(input int m, input int y);
      int r;
      int len;
      r = $urandom_range(0, 99);
      len = days_in_month(m, y);
      if (len == 0 || r >= 95) return DAY_W'($urandom_range(0, 31));
      else if (r < 70) return DAY_W'($urandom_range(1, len));
      else if (r < 80) return DAY_W'(len);
      else if (r < 85) return DAY_W'(1);
      else if (r < 90) return DAY_W'($urandom_range(29, 31));
      else return '0;
   endfunction

   function automatic cal_date_type random_date(input logic [YEAR_W-1:0] y);
      cal_date_type d;
      d.year  = y;
      d.month = random_month();
      d.day   = random_day(int'(d.month), int'(d.year));
      return d;
   endfunction

   function automatic date_pair_type random_pair();
      date_pair_type p;
      int            r;
      r = $urandom_range(0, 99);
      p.drain_first = 1'b0;
      p.a = random_date(random_year());
      if (r < 10) p.b = p.a;
      else if (r < 40) p.b = random_date(p.a.year);
      else p.b = random_date(random_year());
      return p;
   endfunction

   task automatic add_pair(input int ma, input int da, input int ya,
                           input int mb, input int db, input int yb);
      date_pair_type p;
      p.a.month = MONTH_W'(ma);
      p.a.day   = DAY_W'(da);
      p.a.year  = YEAR_W'(ya);
      p.b.month = MONTH_W'(mb);
      p.b.day   = DAY_W'(db);
      p.b.year  = YEAR_W'(yb);
      p.drain_first = 1'b0;
      date_pairs_q = {date_pairs_q, p};
   endtask

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   // ------------------------------------------------------------ driver
   always @(posedge clock) begin : driver
      date_pair_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         tail_phase <= (date_pairs_q.size() <= TAIL_ITEMS);
         if (!req_tvalid || req_tready) begin
            if (req_tvalid) begin
               awaited_counts = {awaited_counts, predict_difference(offered_pair)};
               sent_count++;
            end
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (date_pairs_q.size() != 0 &&
                         (!date_pairs_q[0].drain_first || rsp_count >= sent_count)) begin
               nxt = date_pairs_q.pop_front();
               offered_pair = nxt;
               req_tvalid <= 1'b1;
               req_tdata  <= pack_pair(nxt);
               if (!tail_phase && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------ monitor
   always @(posedge clock) begin : monitor
      day_count_type got;
      day_count_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.valid_a = rsp_tuser[0];
            got.valid_b = rsp_tuser[1];
            got.order   = rsp_tdata[1:0];
            got.diff    = rsp_tdata[24:2];
            if (awaited_counts.size() == 0) begin
               flag_error($sformatf("response %0d with nothing awaited", rsp_count));
            end else begin
               want = awaited_counts.pop_front();
               if (got.valid_a !== want.valid_a)
                  flag_error($sformatf("response %0d valid_a %0b, want %0b",
                                       rsp_count, got.valid_a, want.valid_a));
               if (got.valid_b !== want.valid_b)
                  flag_error($sformatf("response %0d valid_b %0b, want %0b",
                                       rsp_count, got.valid_b, want.valid_b));
               if (got.order !== want.order)
                  flag_error($sformatf("response %0d order %0d, want %0d",
                                       rsp_count, got.order, want.order));
               if (got.diff !== want.diff)
                  flag_error($sformatf("response %0d day_difference %0d, want %0d",
                                       rsp_count, got.diff, want.diff));
               if (rsp_tdata[31:25] !== '0)
                  flag_error($sformatf("response %0d pad bits %b", rsp_count,
                                       rsp_tdata[31:25]));
            end
            // hold off once the directed set is through, while the burst queues up
            if (rsp_count + 1 == directed_count) hold_left = LONG_HOLD;
            rsp_count <= rsp_count + 1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------ watchdog
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------ sequence
   initial begin : stimulus
      date_pair_type p;
      // directed: range ends, leap rules, each kind of invalid field
      add_pair(1, 1, 1, 1, 1, 1);
      add_pair(12, 31, LAST_YEAR, 1, 1, 1);
      add_pair(1, 1, 1, 12, 31, LAST_YEAR);
      add_pair(12, 31, LAST_YEAR, 12, 31, LAST_YEAR);
      add_pair(2, 29, 2000, 2, 28, 2000);
      add_pair(2, 29, 1900, 3, 1, 1900);
      add_pair(2, 29, 2004, 3, 1, 2003);
      add_pair(2, 29, 2001, 1, 1, 2001);
      add_pair(3, 1, 400, 2, 29, 400);
      add_pair(0, 10, 2020, 1, 1, 2020);
      add_pair(13, 1, 2020, 14, 1, 2020);
      add_pair(15, 31, 16383, 15, 31, 16383);
      add_pair(0, 0, 0, 0, 0, 0);
      add_pair(4, 31, 1999, 4, 30, 1999);
      add_pair(6, 30, 1999, 6, 0, 1999);
      add_pair(1, 1, 0, 1, 1, 1);
      add_pair(12, 31, LAST_YEAR + 1, 1, 1, 1);
      add_pair(1, 1, 5, 1, 1, LAST_YEAR + 1);
      add_pair(7, 4, 1776, 7, 4, 2024);
      add_pair(1, 31, 100, 2, 1, 100);
      add_pair(12, 31, 8191, 1, 1, 8192);
      add_pair(11, 30, 5000, 9, 15, 4999);
      add_pair(10, 31, 1582, 10, 15, 1582);
      directed_count = date_pairs_q.size();

      // short queries sent while the receiver holds off
      for (int i = 0; i < BURST_ITEMS; i++) begin
         p.a = random_date(YEAR_W'($urandom_range(1, 30)));
         p.b = random_date(YEAR_W'($urandom_range(1, 30)));
         p.drain_first = (i == 0);
         date_pairs_q = {date_pairs_q, p};
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         p = random_pair();
         p.drain_first = ($urandom_range(0, 39) == 0);
         date_pairs_q = {date_pairs_q, p};
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (date_pairs_q.size() != 0 || req_tvalid || awaited_counts.size() != 0);

      repeat (LAST_YEAR + 8) @(posedge clock);
      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
